// ===== rtl/core/bmmd_pkg.sv =====
// ---------------------------------------------------------------------------
// bmmd_pkg
// Shared types and constants for the banked memory map decoder: bus opcodes,
// address map boundaries, bank controller sizes and read-data select codes.
// ---------------------------------------------------------------------------
package bmmd_pkg;

    typedef logic [1:0]  op_t;
    typedef logic [15:0] bus_addr_t;
    typedef logic [7:0]  byte_t;
    typedef logic [18:0] image_addr_t;
    typedef logic [2:0]  sel_t;

    // bus opcodes
    localparam op_t OP_READ    = 2'd0;
    localparam op_t OP_WRITE   = 2'd1;
    localparam op_t OP_PRELOAD = 2'd2;

    // cartridge geometry
    localparam int ROM_BANKS       = 32;
    localparam int RAM_BANK_BYTES  = 8192;
    localparam int ROM_BANK_BYTES  = 16384;
    localparam int ROM_DEPTH       = 524288;
    localparam int CART_RAM_DEPTH  = 32768;
    localparam int ROM_OFS_W       = $clog2(ROM_BANK_BYTES);
    localparam int ROM_IDX_W       = $clog2(ROM_DEPTH);
    localparam int ROM_BANK_SEL_W  = ROM_IDX_W - ROM_OFS_W;
    localparam int CART_OFS_W      = $clog2(RAM_BANK_BYTES);
    localparam int CART_IDX_W      = $clog2(CART_RAM_DEPTH);
    localparam int VRAM_DEPTH      = 8192;
    localparam int WRAM_DEPTH      = 8192;
    localparam int OAM_DEPTH       = 160;
    localparam int IO_DEPTH        = 128;
    localparam int HRAM_DEPTH      = 127;

    // address map
    localparam bus_addr_t ADDR_VRAM_LO = 16'h8000;
    localparam bus_addr_t ADDR_OAM_LO  = 16'hFE00;
    localparam bus_addr_t ADDR_OAM_END = 16'hFEA0;
    localparam bus_addr_t ADDR_IO_LO   = 16'hFF00;
    localparam bus_addr_t ADDR_HRAM_LO = 16'hFF80;
    localparam bus_addr_t ADDR_IE      = 16'hFFFF;
    localparam bus_addr_t ADDR_DIV     = 16'hFF04;

    // upper address bits [15:13] of the 8 KB windows
    localparam logic [2:0] WIN_VRAM = 3'b100;
    localparam logic [2:0] WIN_CART = 3'b101;
    localparam logic [2:0] WIN_WRAM = 3'b110;

    // bank controller register windows, address bits [14:13]
    localparam logic [1:0] MBC_RAM_EN   = 2'd0;
    localparam logic [1:0] MBC_ROM_LOW  = 2'd1;
    localparam logic [1:0] MBC_UPPER    = 2'd2;
    localparam logic [1:0] MBC_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_KEY   = 4'hA;

    // read data source
    localparam sel_t SEL_DIRECT = 3'd0;
    localparam sel_t SEL_ROM    = 3'd1;
    localparam sel_t SEL_VRAM   = 3'd2;
    localparam sel_t SEL_CART   = 3'd3;
    localparam sel_t SEL_WRAM   = 3'd4;
    localparam sel_t SEL_OAM    = 3'd5;
    localparam sel_t SEL_IO     = 3'd6;
    localparam sel_t SEL_HRAM   = 3'd7;

endpackage

// ===== rtl/core/banked_memory_map_decoder.sv =====
// ---------------------------------------------------------------------------
// banked_memory_map_decoder
// Decodes one bus access or image preload per word across the fixed memory
// map, runs the bank controller and returns the read byte and divider clear.
// ---------------------------------------------------------------------------
// pipeline: input register, then decode plus one memory access into the
// result register
// throughput: one word per cycle while out_ready allows; every memory has a
// single port and the bank controller updates in the same cycle as the access
// reset: pipeline empty, rom bank 1, ram bank 0, cart ram disabled, rom
// banking mode, interrupt enable 0; memory contents are not cleared
module banked_memory_map_decoder (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bmmd_pkg::op_t           op,
    input  bmmd_pkg::bus_addr_t     addr,
    input  bmmd_pkg::byte_t         wdata,
    input  bmmd_pkg::image_addr_t   image_addr,
    input  bmmd_pkg::byte_t         divider_high,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bmmd_pkg::byte_t         rdata,
    output logic                    divider_clear
);
    import bmmd_pkg::*;

    // input register
    logic          s1_valid_reg;
    op_t           s1_op_reg;
    bus_addr_t     s1_addr_reg;
    byte_t         s1_wdata_reg;
    image_addr_t   s1_image_addr_reg;
    byte_t         s1_div_reg;

    // result register
    logic          out_valid_reg;
    sel_t          sel_reg;
    sel_t          sel_next;
    byte_t         direct_reg;
    byte_t         direct_next;
    logic          clear_reg;
    logic          clear_next;

    // bank controller
    logic [6:0]    rom_bank_reg;
    logic [1:0]    ram_bank_reg;
    logic          ram_enable_reg;
    logic          banking_mode_reg;
    byte_t         ie_reg;

    // memories
    byte_t rom_mem  [ROM_DEPTH];
    byte_t cart_mem [CART_RAM_DEPTH];
    byte_t vram_mem [VRAM_DEPTH];
    byte_t wram_mem [WRAM_DEPTH];
    byte_t oam_mem  [OAM_DEPTH];
    byte_t io_mem   [IO_DEPTH];
    byte_t hram_mem [HRAM_DEPTH];

    byte_t rom_rd_reg;
    byte_t cart_rd_reg;
    byte_t vram_rd_reg;
    byte_t wram_rd_reg;
    byte_t oam_rd_reg;
    byte_t io_rd_reg;
    byte_t hram_rd_reg;

    logic advance;
    logic fire;
    logic is_read;
    logic is_write;
    logic is_preload;
    logic in_rom;
    logic in_vram;
    logic in_cart;
    logic in_wram;
    logic in_oam;
    logic in_io;
    logic in_hram;
    logic in_ie;
    logic is_div;

    logic [6:0]                 bank_mod [128];
    logic [6:0]                 rom_bank_eff;
    logic [ROM_BANK_SEL_W-1:0]  rom_bank_sel;
    logic [ROM_IDX_W-1:0]       rom_idx;
    logic [CART_IDX_W-1:0]      cart_idx;
    logic [4:0]                 low_bits;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg         <= op;
            s1_addr_reg       <= addr;
            s1_wdata_reg      <= wdata;
            s1_image_addr_reg <= image_addr;
            s1_div_reg        <= divider_high;
        end
    end

    // address decode
    assign is_read    = s1_op_reg == OP_READ;
    assign is_write   = s1_op_reg == OP_WRITE;
    assign is_preload = s1_op_reg == OP_PRELOAD;
    assign in_rom     = s1_addr_reg < ADDR_VRAM_LO;
    assign in_vram    = s1_addr_reg[15:13] == WIN_VRAM;
    assign in_cart    = s1_addr_reg[15:13] == WIN_CART;
    assign in_wram    = s1_addr_reg[15:13] == WIN_WRAM;
    assign in_oam     = s1_addr_reg >= ADDR_OAM_LO && s1_addr_reg < ADDR_OAM_END;
    assign in_io      = s1_addr_reg >= ADDR_IO_LO && s1_addr_reg < ADDR_HRAM_LO;
    assign in_hram    = s1_addr_reg >= ADDR_HRAM_LO && s1_addr_reg != ADDR_IE;
    assign in_ie      = s1_addr_reg == ADDR_IE;
    assign is_div     = s1_addr_reg == ADDR_DIV;

    // bank number modulo the cartridge bank count, as a constant table
    for (genvar g = 0; g < 128; g++)
    begin : g_bank_mod
        assign bank_mod[g] = 7'(g % ROM_BANKS);
    end

    assign rom_bank_eff = bank_mod[rom_bank_reg];
    assign rom_bank_sel = s1_addr_reg[ROM_OFS_W] ? rom_bank_eff[ROM_BANK_SEL_W-1:0]
                                                 : '0;
    assign rom_idx      = is_preload ? s1_image_addr_reg
                                     : {rom_bank_sel, s1_addr_reg[ROM_OFS_W-1:0]};
    assign cart_idx     = {ram_bank_reg, s1_addr_reg[CART_OFS_W-1:0]};
    assign low_bits     = s1_wdata_reg[4:0];

    // bank controller and interrupt enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg     <= 7'd1;
            ram_bank_reg     <= 2'd0;
            ram_enable_reg   <= 1'b0;
            banking_mode_reg <= 1'b0;
            ie_reg           <= '0;
        end
        else if (fire && is_write)
        begin
            if (in_rom)
            begin
                unique case (s1_addr_reg[14:13])
                    MBC_RAM_EN:
                    begin
                        ram_enable_reg <= s1_wdata_reg[3:0] == RAM_EN_KEY;
                    end
                    MBC_ROM_LOW:
                    begin
                        // a zero bank in the low five bits maps to the next one
                        rom_bank_reg[4:0] <= (low_bits == 5'd0) ? 5'd1 : low_bits;
                    end
                    MBC_UPPER:
                    begin
                        if (!banking_mode_reg)
                        begin
                            rom_bank_reg[6:5] <= s1_wdata_reg[1:0];
                        end
                        else
                        begin
                            ram_bank_reg <= s1_wdata_reg[1:0];
                        end
                    end
                    MBC_MODE:
                    begin
                        banking_mode_reg <= s1_wdata_reg[0];
                    end
                    default:
                    begin
                        banking_mode_reg <= banking_mode_reg;
                    end
                endcase
            end
            if (in_ie)
            begin
                ie_reg <= s1_wdata_reg;
            end
        end
    end

    // memories: one access per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (fire && (is_preload || (is_read && in_rom)))
        begin
            if (is_preload)
            begin
                rom_mem[rom_idx] <= s1_wdata_reg;
            end
            rom_rd_reg <= rom_mem[rom_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_cart && ram_enable_reg)
        begin
            if (is_write)
            begin
                cart_mem[cart_idx] <= s1_wdata_reg;
            end
            cart_rd_reg <= cart_mem[cart_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_vram)
        begin
            if (is_write)
            begin
                vram_mem[s1_addr_reg[12:0]] <= s1_wdata_reg;
            end
            vram_rd_reg <= vram_mem[s1_addr_reg[12:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_wram)
        begin
            if (is_write)
            begin
                wram_mem[s1_addr_reg[12:0]] <= s1_wdata_reg;
            end
            wram_rd_reg <= wram_mem[s1_addr_reg[12:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_oam)
        begin
            if (is_write)
            begin
                oam_mem[s1_addr_reg[7:0]] <= s1_wdata_reg;
            end
            oam_rd_reg <= oam_mem[s1_addr_reg[7:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_io && !is_div)
        begin
            if (is_write)
            begin
                io_mem[s1_addr_reg[6:0]] <= s1_wdata_reg;
            end
            io_rd_reg <= io_mem[s1_addr_reg[6:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_hram)
        begin
            if (is_write)
            begin
                hram_mem[s1_addr_reg[6:0]] <= s1_wdata_reg;
            end
            hram_rd_reg <= hram_mem[s1_addr_reg[6:0]];
        end
    end

    // result source selection
    always_comb
    begin
        sel_next    = SEL_DIRECT;
        direct_next = '0;
        clear_next  = is_write && is_div;
        if (is_read)
        begin
            if (in_rom)
            begin
                sel_next = SEL_ROM;
            end
            else if (in_vram)
            begin
                sel_next = SEL_VRAM;
            end
            else if (in_cart)
            begin
                if (ram_enable_reg)
                begin
                    sel_next = SEL_CART;
                end
                else
                begin
                    direct_next = 8'hFF;
                end
            end
            else if (in_wram)
            begin
                sel_next = SEL_WRAM;
            end
            else if (in_oam)
            begin
                sel_next = SEL_OAM;
            end
            else if (in_io)
            begin
                if (is_div)
                begin
                    direct_next = s1_div_reg;
                end
                else
                begin
                    sel_next = SEL_IO;
                end
            end
            else if (in_hram)
            begin
                sel_next = SEL_HRAM;
            end
            else if (in_ie)
            begin
                direct_next = ie_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sel_reg    <= sel_next;
            direct_reg <= direct_next;
            clear_reg  <= clear_next;
        end
    end

    always_comb
    begin
        unique case (sel_reg)
            SEL_ROM:  rdata = rom_rd_reg;
            SEL_VRAM: rdata = vram_rd_reg;
            SEL_CART: rdata = cart_rd_reg;
            SEL_WRAM: rdata = wram_rd_reg;
            SEL_OAM:  rdata = oam_rd_reg;
            SEL_IO:   rdata = io_rd_reg;
            SEL_HRAM: rdata = hram_rd_reg;
            default:  rdata = direct_reg;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign divider_clear = clear_reg;

`ifndef SYNTHESIS
    a_rom_bank_low_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rom_bank_reg[4:0] != 5'd0)
        else $error("rom bank low bits are zero");

    a_clear_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divider_clear |-> rdata == 8'd0)
        else $error("divider clear with nonzero read data");

    a_mode1_keeps_rom_bank: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_write && in_rom && s1_addr_reg[14:13] == MBC_UPPER && banking_mode_reg
        |=> $stable(rom_bank_reg))
        else $error("upper bits write in ram banking mode changed rom bank");

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("input word dropped while output stalled");
`endif

endmodule

// ===== sim/banked_memory_map_decoder_test.sv =====
// ---------------------------------------------------------------------------
// banked_memory_map_decoder_test
// Drives bus reads and writes, image preloads and undefined opcodes into the
// decoder through its valid/ready ports. A shadow copy of the memory map and
// bank controller predicts every result, and each word returned is compared
// field by field. Random reads target known bytes only. Both ports idle at
// random, and the result port holds off once long enough to stall the input.
// ---------------------------------------------------------------------------
module banked_memory_map_decoder_test;

    import bmmd_pkg::*;

    localparam op_t       OP_UNDEF     = 2'd3;
    localparam bus_addr_t ADDR_ROMX_LO = 16'h4000;
    localparam bus_addr_t ADDR_CART_LO = 16'hA000;
    localparam bus_addr_t ADDR_WRAM_LO = 16'hC000;
    localparam bus_addr_t ADDR_ECHO_LO = 16'hE000;

    localparam int RANDOM_WORDS = 1925;
    localparam int IDLE_PCT     = 17;
    localparam int HOLD_START   = 1700;
    localparam int HOLD_CYCLES  = 120;
    localparam int LOG_LIMIT    = 100;

    // shadow stores, keyed by store id and byte index
    localparam int STORE_ROM  = 0;
    localparam int STORE_CART = 1;
    localparam int STORE_VRAM = 2;
    localparam int STORE_WRAM = 3;
    localparam int STORE_OAM  = 4;
    localparam int STORE_IO   = 5;
    localparam int STORE_HRAM = 6;
    localparam int NUM_STORES = 7;
    localparam int STORE_SHIFT = 20;

    typedef enum int {
        AREA_ROM, AREA_VRAM, AREA_CART, AREA_WRAM, AREA_OAM, AREA_IO,
        AREA_HRAM, AREA_IE, AREA_ECHO, AREA_UNUSED, AREA_DIV
    } area_t;

    typedef struct packed {
        op_t         op;
        bus_addr_t   addr;
        byte_t       wdata;
        image_addr_t image_addr;
        byte_t       divider_high;
    } bus_word_t;

    typedef struct packed {
        byte_t rdata;
        logic  divider_clear;
    } bus_result_t;

    typedef struct packed {
        bus_word_t   word;
        logic        pinned;
        bus_result_t result;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    op_t         op;
    bus_addr_t   addr;
    byte_t       wdata;
    image_addr_t image_addr;
    byte_t       divider_high;
    logic        out_valid;
    logic        out_ready;
    byte_t       rdata;
    logic        divider_clear;

    // shadow of the bank controller
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       cart_on;
    logic       bank_mode;
    byte_t      ie_reg;

    byte_t       shadow_mem[int];
    int          written_idx[NUM_STORES][$];
    bus_result_t pending_results[$];
    int          mismatch_count;
    int          words_sent;

    // pinned rows carry a result that is obvious from the map
    stim_row_t directed_rows [0:26] = '{
        '{'{OP_READ,    16'hFFFF, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'hA000, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
        '{'{OP_READ,    16'hE000, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'hFEFF, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'hFF04, 8'h00, 19'h00000, 8'hA5}, 1'b1, '{8'hA5, 1'b0}},
        '{'{OP_WRITE,   16'hFF04, 8'h3C, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b1}},
        '{'{OP_UNDEF,   16'hFF04, 8'h3C, 19'h7FFFF, 8'h5A}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_PRELOAD, 16'h0000, 8'h5A, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_PRELOAD, 16'hFFFF, 8'hC3, 19'h7FFFF, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_PRELOAD, 16'h4000, 8'h11, 19'h04000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'h0000, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'h5A, 1'b0}},
        '{'{OP_READ,    16'h4000, 8'h00, 19'h00000, 8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'h2000, 8'h1F, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'h7FFF, 8'h00, 19'h00000, 8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'h4000, 8'hFF, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'h7FFF, 8'h00, 19'h00000, 8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'h3FFF, 8'hE0, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'h4000, 8'h00, 19'h00000, 8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'h6000, 8'h01, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'h5FFF, 8'h03, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'h0000, 8'h0A, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'hBFFF, 8'h77, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'hBFFF, 8'h00, 19'h00000, 8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{OP_WRITE,   16'h1FFF, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'hBFFF, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
        '{'{OP_WRITE,   16'hFFFF, 8'hFF, 19'h00000, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{OP_READ,    16'hFFFF, 8'h00, 19'h00000, 8'h00}, 1'b1, '{8'hFF, 1'b0}}
    };

    banked_memory_map_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .addr          (addr),
        .wdata         (wdata),
        .image_addr    (image_addr),
        .divider_high  (divider_high),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rdata         (rdata),
        .divider_clear (divider_clear)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        // keep the log short when everything goes wrong
        if (mismatch_count < LOG_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void store_byte(input int store, input int idx, input byte_t d);
        int key;
        key = (store << STORE_SHIFT) | idx;
        if (!shadow_mem.exists(key))
            written_idx[store].push_back(idx);
        shadow_mem[key] = d;
    endfunction

    function automatic byte_t fetch_byte(input int store, input int idx);
        int key;
        key = (store << STORE_SHIFT) | idx;
        return shadow_mem.exists(key) ? shadow_mem[key] : 8'h00;
    endfunction

    function automatic int rom_index(input bus_addr_t a);
        if (a < ADDR_ROMX_LO)
            return int'(a);
        return ((int'(rom_bank) % ROM_BANKS) * ROM_BANK_BYTES + int'(a[13:0])) % ROM_DEPTH;
    endfunction

    function automatic int cart_index(input bus_addr_t a);
        return (int'(ram_bank) * RAM_BANK_BYTES + int'(a[12:0])) % CART_RAM_DEPTH;
    endfunction

    function automatic byte_t read_map(input bus_addr_t a, input byte_t div);
        if (a < ADDR_VRAM_LO)
            return fetch_byte(STORE_ROM, rom_index(a));
        if (a[15:13] == WIN_VRAM)
            return fetch_byte(STORE_VRAM, int'(a[12:0]));
        if (a[15:13] == WIN_CART)
            return cart_on ? fetch_byte(STORE_CART, cart_index(a)) : 8'hFF;
        if (a[15:13] == WIN_WRAM)
            return fetch_byte(STORE_WRAM, int'(a[12:0]));
        if (a >= ADDR_OAM_LO && a < ADDR_OAM_END)
            return fetch_byte(STORE_OAM, int'(a - ADDR_OAM_LO));
        if (a >= ADDR_IO_LO && a < ADDR_HRAM_LO)
            return (a == ADDR_DIV) ? div : fetch_byte(STORE_IO, int'(a - ADDR_IO_LO));
        if (a >= ADDR_HRAM_LO && a < ADDR_IE)
            return fetch_byte(STORE_HRAM, int'(a - ADDR_HRAM_LO));
        if (a == ADDR_IE)
            return ie_reg;
        return 8'h00;
    endfunction

    function automatic void program_bank_ctrl(input bus_addr_t a, input byte_t d);
        logic [6:0] b;
        case (a[14:13])
            MBC_RAM_EN:
                cart_on = (d[3:0] == RAM_EN_KEY);
            MBC_ROM_LOW:
            begin
                // low five bits of zero select the next bank up
                b = {rom_bank[6:5], d[4:0]};
                if (d[4:0] == 5'd0)
                    b = b + 7'd1;
                rom_bank = b;
            end
            MBC_UPPER:
            begin
                if (!bank_mode)
                    rom_bank[6:5] = d[1:0];
                else
                    ram_bank = d[1:0];
            end
            default:
                bank_mode = d[0];
        endcase
    endfunction

    function automatic void write_map(input bus_addr_t a, input byte_t d);
        if (a < ADDR_VRAM_LO)
            program_bank_ctrl(a, d);
        else if (a[15:13] == WIN_VRAM)
            store_byte(STORE_VRAM, int'(a[12:0]), d);
        else if (a[15:13] == WIN_CART)
        begin
            if (cart_on)
                store_byte(STORE_CART, cart_index(a), d);
        end
        else if (a[15:13] == WIN_WRAM)
            store_byte(STORE_WRAM, int'(a[12:0]), d);
        else if (a >= ADDR_OAM_LO && a < ADDR_OAM_END)
            store_byte(STORE_OAM, int'(a - ADDR_OAM_LO), d);
        else if (a >= ADDR_IO_LO && a < ADDR_HRAM_LO)
        begin
            if (a != ADDR_DIV)
                store_byte(STORE_IO, int'(a - ADDR_IO_LO), d);
        end
        else if (a >= ADDR_HRAM_LO && a < ADDR_IE)
            store_byte(STORE_HRAM, int'(a - ADDR_HRAM_LO), d);
        else if (a == ADDR_IE)
            ie_reg = d;
    endfunction

    // applies one accepted word to the shadow map and returns its result
    function automatic bus_result_t decode_access(input bus_word_t w);
        bus_result_t r;
        r = '0;
        case (w.op)
            OP_PRELOAD:
                store_byte(STORE_ROM, int'(w.image_addr), w.wdata);
            OP_READ:
                r.rdata = read_map(w.addr, w.divider_high);
            OP_WRITE:
            begin
                r.divider_clear = (w.addr == ADDR_DIV);
                write_map(w.addr, w.wdata);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int hot_offset(input int span);
        case ($urandom_range(3))
            0: return $urandom_range(span - 1);
            1: return $urandom_range(15);
            2: return span - 1 - $urandom_range(15);
            default: return $urandom_range(63);
        endcase
    endfunction

    function automatic int pick_written(input int store);
        if (written_idx[store].size() == 0)
            return -1;
        return written_idx[store][$urandom_range(written_idx[store].size() - 1)];
    endfunction

    function automatic bus_addr_t write_addr(input area_t ar);
        case (ar)
            AREA_VRAM:   return ADDR_VRAM_LO + bus_addr_t'(hot_offset(VRAM_DEPTH));
            AREA_CART:   return ADDR_CART_LO + bus_addr_t'(hot_offset(RAM_BANK_BYTES));
            AREA_WRAM:   return ADDR_WRAM_LO + bus_addr_t'(hot_offset(WRAM_DEPTH));
            AREA_OAM:    return ADDR_OAM_LO + bus_addr_t'(hot_offset(OAM_DEPTH));
            AREA_IO:     return ADDR_IO_LO + bus_addr_t'(hot_offset(IO_DEPTH));
            AREA_HRAM:   return ADDR_HRAM_LO + bus_addr_t'(hot_offset(HRAM_DEPTH));
            AREA_IE:     return ADDR_IE;
            AREA_ECHO:
                return ADDR_ECHO_LO + bus_addr_t'($urandom_range(ADDR_OAM_LO - ADDR_ECHO_LO - 1));
            AREA_UNUSED:
                return ADDR_OAM_END + bus_addr_t'($urandom_range(ADDR_IO_LO - ADDR_OAM_END - 1));
            default:     return ADDR_DIV;
        endcase
    endfunction

    // only addresses whose byte is known; falls back to the enable byte
    function automatic bus_addr_t read_addr(input area_t ar);
        int idx;
        int cur;
        cur = int'(rom_bank) % ROM_BANKS;
        case (ar)
            AREA_ROM:
                repeat (8)
                begin
                    idx = pick_written(STORE_ROM);
                    if (idx >= 0 && idx / ROM_BANK_BYTES == cur)
                        return ADDR_ROMX_LO + bus_addr_t'(idx % ROM_BANK_BYTES);
                    if (idx >= 0 && idx < ROM_BANK_BYTES)
                        return bus_addr_t'(idx);
                end
            AREA_CART:
            begin
                if (!cart_on)
                    return write_addr(AREA_CART);
                repeat (8)
                begin
                    idx = pick_written(STORE_CART);
                    if (idx >= 0 && idx / RAM_BANK_BYTES == int'(ram_bank))
                        return ADDR_CART_LO + bus_addr_t'(idx % RAM_BANK_BYTES);
                end
            end
            AREA_VRAM:
            begin
                idx = pick_written(STORE_VRAM);
                if (idx >= 0)
                    return ADDR_VRAM_LO + bus_addr_t'(idx);
            end
            AREA_WRAM:
            begin
                idx = pick_written(STORE_WRAM);
                if (idx >= 0)
                    return ADDR_WRAM_LO + bus_addr_t'(idx);
            end
            AREA_OAM:
            begin
                idx = pick_written(STORE_OAM);
                if (idx >= 0)
                    return ADDR_OAM_LO + bus_addr_t'(idx);
            end
            AREA_IO:
            begin
                idx = pick_written(STORE_IO);
                if (idx >= 0)
                    return ADDR_IO_LO + bus_addr_t'(idx);
            end
            AREA_HRAM:
            begin
                idx = pick_written(STORE_HRAM);
                if (idx >= 0)
                    return ADDR_HRAM_LO + bus_addr_t'(idx);
            end
            default:
                return write_addr(ar);
        endcase
        return ADDR_IE;
    endfunction

    function automatic bus_word_t make_random_word();
        bus_word_t w;
        int pick;
        w.op           = OP_READ;
        w.addr         = bus_addr_t'($urandom);
        w.wdata        = byte_t'($urandom);
        w.image_addr   = image_addr_t'($urandom);
        w.divider_high = byte_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            // most image bytes land where the next reads can reach them
            w.op = OP_PRELOAD;
            case ($urandom_range(2))
                0: w.image_addr = image_addr_t'(hot_offset(ROM_BANK_BYTES));
                1: w.image_addr = image_addr_t'((int'(rom_bank) % ROM_BANKS) * ROM_BANK_BYTES
                                                + hot_offset(ROM_BANK_BYTES));
                default: ;
            endcase
        end
        else if (pick < 23)
        begin
            w.op = OP_WRITE;
            w.addr[15] = 1'b0;
            if (w.addr[14:13] == MBC_RAM_EN && $urandom_range(1) == 0)
                w.wdata[3:0] = RAM_EN_KEY;
            if (w.addr[14:13] == MBC_ROM_LOW && $urandom_range(4) == 0)
                w.wdata[4:0] = 5'd0;
        end
        else if (pick < 50)
        begin
            w.op = OP_WRITE;
            w.addr = write_addr(area_t'($urandom_range(AREA_DIV, AREA_VRAM)));
        end
        else if (pick < 98)
        begin
            if ($urandom_range(3) == 0)
                w.addr = read_addr(AREA_ROM);
            else
                w.addr = read_addr(area_t'($urandom_range(AREA_DIV)));
        end
        else
            w.op = OP_UNDEF;
        return w;
    endfunction

    // returns at the edge where the word is taken
    task automatic offer_word(input bus_word_t w);
        logic quiet;
        quiet = (words_sent >= 650 && words_sent < 1050);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= w.op;
        addr         <= w.addr;
        wdata        <= w.wdata;
        image_addr   <= w.image_addr;
        divider_high <= w.divider_high;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic check_result();
        bus_result_t exp;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word rdata=%h divider_clear=%b",
                                      rdata, divider_clear));
            return;
        end
        exp = pending_results.pop_front();
        if (rdata !== exp.rdata)
            report_mismatch($sformatf("rdata %h, expected %h", rdata, exp.rdata));
        if (divider_clear !== exp.divider_clear)
            report_mismatch($sformatf("divider_clear %b, expected %b",
                                      divider_clear, exp.divider_clear));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
    end

    // result side: random stalls, a quiet stretch and one long hold-off
    initial
    begin
        int ready_cycles;
        ready_cycles = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            ready_cycles++;
            if (ready_cycles == HOLD_START)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                ready_cycles += HOLD_CYCLES;
            end
            if (ready_cycles >= 900 && ready_cycles < 1500)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        bus_word_t   w;
        bus_result_t r;
        int          drain;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_READ;
        addr         = '0;
        wdata        = '0;
        image_addr   = '0;
        divider_high = '0;
        rom_bank     = 7'd1;
        ram_bank     = 2'd0;
        cart_on      = 1'b0;
        bank_mode    = 1'b0;
        ie_reg       = 8'h00;
        mismatch_count = 0;
        words_sent   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_word(directed_rows[i].word);
            r = decode_access(directed_rows[i].word);
            pending_results.push_back(directed_rows[i].pinned ? directed_rows[i].result : r);
        end
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            w = make_random_word();
            offer_word(w);
            pending_results.push_back(decode_access(w));
        end
        in_valid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 10000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bmmd_pkg.sv
rtl/core/banked_memory_map_decoder.sv
sim/banked_memory_map_decoder_test.sv
